### hdl/ata_pkg.sv
package ata_pkg;
   localparam int AXIS_W = 14;
   localparam int ANGLE_W = 15;
   localparam int SQ_W = 28;
   localparam int ROOT_W = 14;
   localparam int VEC_W = 30;
   localparam int ACC_W = 22;
   localparam int TABLE_LEN = 24;
   localparam int HALF_PI_Q13 = 12868;

   // atan(2^-i) in units of 2^-20 rad
   function automatic logic signed [ACC_W-1:0] atan_q20(input int idx);
      logic signed [ACC_W-1:0] t;
      unique case (idx)
         0: t = 22'sd823550;
         1: t = 22'sd486170;
         2: t = 22'sd256879;
         3: t = 22'sd130396;
         4: t = 22'sd65451;
         5: t = 22'sd32757;
         6: t = 22'sd16383;
         7: t = 22'sd8192;
         8: t = 22'sd4096;
         9: t = 22'sd2048;
         10: t = 22'sd1024;
         11: t = 22'sd512;
         12: t = 22'sd256;
         13: t = 22'sd128;
         14: t = 22'sd64;
         15: t = 22'sd32;
         16: t = 22'sd16;
         17: t = 22'sd8;
         18: t = 22'sd4;
         19: t = 22'sd2;
         20: t = 22'sd1;
         default: t = '0;
      endcase
      return t;
   endfunction

   typedef struct packed {
      logic valid;
      logic signed [AXIS_W-1:0] axis;
   } lane_tag_type;
endpackage

### hdl/accel_tilt_angles.sv
// accel_tilt_angles: pitch, roll and yaw tilt angles from one accelerometer sample
// input: drive req_accel_x/y/z with start high; a beat is taken at any edge where
//   start is high and busy is low. busy is always low, so a sample may enter
//   every cycle.
// output: rsp_valid strobes for one cycle with rsp_pitch_angle, rsp_roll_angle
//   and rsp_yaw_angle, angles in radians times 8192.
// pipeline: the input register, the squaring stage, the 14 square-root stages
//   (one root bit each), one stage per CORDIC rotation (CORDIC_STEPS, capped
//   at 24) and the output rounding stage; throughput one sample per cycle.
// results leave in acceptance order; the receiver cannot stall, so each
// strobe must be consumed when it appears.
// reset (synchronous, active high) clears all valid bits; payload in flight
// is dropped and no strobe follows until new samples enter.
module accel_tilt_angles
   import ata_pkg::*;
#(
   parameter int CORDIC_STEPS = 14
)(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [AXIS_W-1:0] req_accel_x,
   input  logic signed [AXIS_W-1:0] req_accel_y,
   input  logic signed [AXIS_W-1:0] req_accel_z,
   output logic rsp_valid,
   output logic signed [ANGLE_W-1:0] rsp_pitch_angle,
   output logic signed [ANGLE_W-1:0] rsp_roll_angle,
   output logic signed [ANGLE_W-1:0] rsp_yaw_angle
);
   assign busy = 1'b0;

   // input register and squares
   logic v0_ff;
   logic signed [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0] sx_ff, sy_ff, sz_ff;
   logic v1_ff;
   logic signed [AXIS_W-1:0] bx_ff, by_ff, bz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
      end
      ax_ff <= req_accel_x;
      ay_ff <= req_accel_y;
      az_ff <= req_accel_z;
      sx_ff <= SQ_W'(ax_ff * ax_ff);
      sy_ff <= SQ_W'(ay_ff * ay_ff);
      sz_ff <= SQ_W'(az_ff * az_ff);
      bx_ff <= ax_ff;
      by_ff <= ay_ff;
      bz_ff <= az_ff;
   end

   logic signed [AXIS_W-1:0] axis_sel [3];
   logic [SQ_W-1:0] sum_sel [3];
   logic vl [3];
   logic signed [ANGLE_W-1:0] ang [3];
   assign axis_sel[0] = bx_ff;
   assign axis_sel[1] = by_ff;
   assign axis_sel[2] = bz_ff;
   assign sum_sel[0] = sy_ff + sz_ff;
   assign sum_sel[1] = sx_ff + sz_ff;
   assign sum_sel[2] = sx_ff + sy_ff;

   // one lane per axis
   for (genvar k = 0; k < 3; k++) begin : g_lane
      lane_tag_type t_in, t_mid;
      logic [ROOT_W-1:0] root;
      assign t_in.valid = v1_ff;
      assign t_in.axis  = axis_sel[k];
      ata_isqrt u_sqrt (
         .clock(clock), .reset(reset), .tag_in(t_in), .sum_in(sum_sel[k]),
         .tag_out(t_mid), .root_out(root)
      );
      ata_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
         .clock(clock), .reset(reset), .tag_in(t_mid), .root_in(root),
         .valid_out(vl[k]), .angle_out(ang[k])
      );
   end

   assign rsp_valid       = vl[0];
   assign rsp_pitch_angle = ang[0];
   assign rsp_roll_angle  = ang[1];
   assign rsp_yaw_angle   = ang[2];

`ifndef SYNTH
   // lanes stay in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      vl[0] == vl[1] && vl[1] == vl[2]) else $error("lane valid mismatch");
   // pitch angle stays within plus or minus pi/2
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868))
      else $error("pitch out of range");
   // nothing emerges right after reset
   a_rst: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("strobe after reset");
`endif
endmodule

### hdl/ata_isqrt.sv
module ata_isqrt
   import ata_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  lane_tag_type tag_in,
   input  logic [SQ_W-1:0] sum_in,
   output lane_tag_type tag_out,
   output logic [ROOT_W-1:0] root_out
);
   localparam int STEPS = ROOT_W;

   lane_tag_type            tag_ff  [1:STEPS];
   logic [SQ_W-1:0]         rem_ff  [1:STEPS];
   logic [ROOT_W-1:0]       res_ff  [1:STEPS];

   // one result bit per stage, restoring method on remainder
   for (genvar s = 0; s < STEPS; s++) begin : g_st
      localparam int B = STEPS - 1 - s;
      lane_tag_type tag_cur;
      logic [SQ_W-1:0] rem_cur;
      logic [ROOT_W-1:0] res_cur;
      logic [SQ_W+1:0] trial;
      logic [SQ_W-1:0] rem_in;
      logic [ROOT_W-1:0] res_in;
      // first stage takes the incoming beat
      if (s == 0) begin : g_head
         assign tag_cur = tag_in;
         assign rem_cur = sum_in;
         assign res_cur = '0;
      end else begin : g_body
         assign tag_cur = tag_ff[s];
         assign rem_cur = rem_ff[s];
         assign res_cur = res_ff[s];
      end
      always_comb begin
         trial = ({2'b00, res_cur} << (B + 1)) + ({{(SQ_W+1){1'b0}}, 1'b1} << (2 * B));
         if ({2'b00, rem_cur} >= trial) begin
            rem_in = rem_cur - trial[SQ_W-1:0];
            res_in = res_cur | (ROOT_W'(1) << B);
         end else begin
            rem_in = rem_cur;
            res_in = res_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) tag_ff[s+1].valid <= 1'b0;
         else tag_ff[s+1].valid <= tag_cur.valid;
         tag_ff[s+1].axis <= tag_cur.axis;
         rem_ff[s+1] <= rem_in;
         res_ff[s+1] <= res_in;
      end
   end

   assign tag_out  = tag_ff[STEPS];
   assign root_out = res_ff[STEPS];
endmodule

### hdl/ata_cordic.sv
module ata_cordic
   import ata_pkg::*;
#(
   parameter int CORDIC_STEPS = 14
)(
   input  logic clock,
   input  logic reset,
   input  lane_tag_type tag_in,
   input  logic [ROOT_W-1:0] root_in,
   output logic valid_out,
   output logic signed [ANGLE_W-1:0] angle_out
);
   localparam int N = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   logic                     v_ff [1:N];
   logic signed [VEC_W-1:0]  x_ff [1:N];
   logic signed [VEC_W-1:0]  y_ff [1:N];
   logic signed [ACC_W-1:0]  z_ff [1:N];
   logic                     zax_ff [1:N];
   logic                     zr_ff [1:N];
   logic                     sg_ff [1:N];

   // vectoring rotations, one per stage
   for (genvar i = 0; i < N; i++) begin : g_rot
      logic v_cur, zax_cur, zr_cur, sg_cur;
      logic signed [VEC_W-1:0] x_cur, y_cur;
      logic signed [ACC_W-1:0] z_cur;
      logic signed [VEC_W-1:0] xs, ys;
      // first stage builds the starting vector
      if (i == 0) begin : g_head
         assign v_cur   = tag_in.valid;
         assign x_cur   = VEC_W'({{(VEC_W-ROOT_W){1'b0}}, root_in} <<< 12);
         assign y_cur   = VEC_W'({{(VEC_W-AXIS_W){tag_in.axis[AXIS_W-1]}}, tag_in.axis} <<< 12);
         assign z_cur   = '0;
         assign zax_cur = (tag_in.axis == '0);
         assign zr_cur  = (root_in == '0);
         assign sg_cur  = tag_in.axis[AXIS_W-1];
      end else begin : g_body
         assign v_cur   = v_ff[i];
         assign x_cur   = x_ff[i];
         assign y_cur   = y_ff[i];
         assign z_cur   = z_ff[i];
         assign zax_cur = zax_ff[i];
         assign zr_cur  = zr_ff[i];
         assign sg_cur  = sg_ff[i];
      end
      assign xs = x_cur >>> i;
      assign ys = y_cur >>> i;
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_cur;
         if (!y_cur[VEC_W-1]) begin
            x_ff[i+1] <= x_cur + ys;
            y_ff[i+1] <= y_cur - xs;
            z_ff[i+1] <= z_cur + atan_q20(i);
         end else begin
            x_ff[i+1] <= x_cur - ys;
            y_ff[i+1] <= y_cur + xs;
            z_ff[i+1] <= z_cur - atan_q20(i);
         end
         zax_ff[i+1] <= zax_cur;
         zr_ff[i+1]  <= zr_cur;
         sg_ff[i+1]  <= sg_cur;
      end
   end

   // round magnitude, clamp, apply special cases
   logic [ACC_W-1:0] mag;
   logic [ACC_W-1:0] q;
   logic signed [ANGLE_W-1:0] ang_in, ang_ff;
   logic vo_ff;
   always_comb begin
      mag = z_ff[N][ACC_W-1] ? ACC_W'(-z_ff[N]) : z_ff[N];
      q = (mag + ACC_W'(64)) >> 7;
      if (q > ACC_W'(HALF_PI_Q13)) q = ACC_W'(HALF_PI_Q13);
      if (zax_ff[N]) ang_in = '0;
      else if (zr_ff[N])
         ang_in = sg_ff[N] ? -ANGLE_W'(HALF_PI_Q13) : ANGLE_W'(HALF_PI_Q13);
      else if (z_ff[N][ACC_W-1]) ang_in = -ANGLE_W'(q);
      else ang_in = ANGLE_W'(q);
   end
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= v_ff[N];
      ang_ff <= ang_in;
   end
   assign valid_out = vo_ff;
   assign angle_out = ang_ff;
endmodule
